@@ hdl/hwjc_pkg.sv @@
// ----------------------------------------------------------------------------
// Hangul code converter package
// Table sizes, derived widths, command codes and the code-page constants used
// by the Wansung and Johab converter.
// ----------------------------------------------------------------------------
package hwjc_pkg;

   localparam int SYLLABLE_ENTRIES = 2350;
   localparam int JAMO_ENTRIES     = 51;

   localparam int CODE_W  = 16;
   localparam int INDEX_W = 12;

   localparam int SYL_AW = (SYLLABLE_ENTRIES > 1) ? $clog2(SYLLABLE_ENTRIES) : 1;
   localparam int SYL_CW = $clog2(SYLLABLE_ENTRIES + 1);
   localparam int JAMO_AW = (JAMO_ENTRIES > 1) ? $clog2(JAMO_ENTRIES) : 1;
   localparam int JAMO_CW = $clog2(JAMO_ENTRIES + 1);
   localparam int ROW_W   = $clog2(SYLLABLE_ENTRIES / 94 + 1);

   localparam int FWD_ROW_W = 5;
   localparam int FWD_COL_W = 7;
   localparam int FWD_POS_W = 12;

   localparam logic [7:0]  JAMO_ROW     = 8'hA4;
   localparam logic [7:0]  COL_FIRST    = 8'hA1;
   localparam logic [7:0]  JAMO_LAST    = 8'hD3;
   localparam logic [7:0]  ROW_FIRST    = 8'hB0;
   localparam logic [7:0]  ROW_LAST     = 8'hC8;
   localparam logic [7:0]  COL_LAST     = 8'hFE;
   localparam logic [7:0]  ROWS_COLS    = 8'd94;
   localparam logic [15:0] JOHAB_FLAG   = 16'h8000;
   localparam logic [15:0] JAMO_WANSUNG = 16'hA4A1;

   typedef enum logic [1:0] {
      CMD_LOAD_SYLLABLE = 2'd0,
      CMD_LOAD_JAMO     = 2'd1,
      CMD_TO_JOHAB      = 2'd2,
      CMD_TO_WANSUNG    = 2'd3
   } cmd_type;

endpackage

@@ hdl/hangul_wansung_johab_converter.sv @@
// ----------------------------------------------------------------------------
// Hangul Wansung and Johab code converter
// Converts 16-bit Korean codes between KS C 5601 and Johab through a stored
// syllable table and a stored jamo table, both filled by load items.
//
//   Channel | Direction | Ports
//   --------+-----------+------------------------------------------------
//   req     | in        | req_valid, req_ready, req_cmd, req_entry_index,
//           |           | req_code_in
//   rsp     | out       | rsp_valid, rsp_ready, rsp_code_out
//
// A load item gives no result and leaves the sequencer idle. A forward item
// passes through ST_FWD, ST_FWD_WAIT and ST_FINISH, bound by the registered
// read of a table memory, or skips ST_FWD_WAIT when no table is read. A reverse
// item passes its code straight through, or makes binary-search probes (at most
// twelve), each a PROBE and a COMPARE state, then splits the position into row
// and column by repeated subtraction or, on a miss, scans the jamo entries in turn.
// Reset returns the sequencer to idle; the tables are undefined until loaded.
// A result waits in the output register; the block accepts the next item
// while it waits, and holds a further result until the register is free.
// ----------------------------------------------------------------------------
module hangul_wansung_johab_converter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  hwjc_pkg::cmd_type                      req_cmd,
   input  logic [hwjc_pkg::INDEX_W-1:0]           req_entry_index,
   input  logic [hwjc_pkg::CODE_W-1:0]            req_code_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [hwjc_pkg::CODE_W-1:0]            rsp_code_out
);

   import hwjc_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_FWD      = 9'b000000010,
      ST_FWD_WAIT = 9'b000000100,
      ST_PROBE    = 9'b000001000,
      ST_COMPARE  = 9'b000010000,
      ST_DIVIDE   = 9'b000100000,
      ST_JREAD    = 9'b001000000,
      ST_JCOMPARE = 9'b010000000,
      ST_FINISH   = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   logic [CODE_W-1:0]      key_ff, key_in;
   logic                   sel_jamo_ff, sel_jamo_in;
   logic [SYL_CW-1:0]      lo_ff, lo_in;
   logic [SYL_CW-1:0]      hi_ff, hi_in;
   logic [SYL_CW-1:0]      mid_ff, mid_in;
   logic [SYL_CW-1:0]      rem_ff, rem_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [JAMO_CW-1:0]     j_ff, j_in;
   logic [CODE_W-1:0]      res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]      code_out_ff, code_out_in;

   logic [CODE_W-1:0]      syl_mem_ff [SYLLABLE_ENTRIES];
   logic [CODE_W-1:0]      jamo_mem_ff [JAMO_ENTRIES];
   logic [CODE_W-1:0]      syl_rd_ff;
   logic [CODE_W-1:0]      jamo_rd_ff;
   logic [SYL_AW-1:0]      syl_addr;
   logic [JAMO_AW-1:0]     jamo_addr;
   logic                   syl_we;
   logic                   jamo_we;

   logic                   accept;
   logic [7:0]             key_hi;
   logic [7:0]             key_lo;
   logic [FWD_ROW_W-1:0]   fwd_row;
   logic [FWD_COL_W-1:0]   fwd_col;
   logic [FWD_POS_W-1:0]   fwd_pos;
   logic [FWD_COL_W-1:0]   fwd_jpos;
   logic [SYL_CW-1:0]      mid_calc;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_code_out = code_out_ff;

   assign key_hi   = key_ff[15:8];
   assign key_lo   = key_ff[7:0];
   assign fwd_row  = FWD_ROW_W'(key_hi - ROW_FIRST);
   assign fwd_col  = FWD_COL_W'(key_lo - COL_FIRST);
   assign fwd_pos  = FWD_POS_W'(FWD_POS_W'(fwd_row) * FWD_POS_W'(ROWS_COLS))
                     + FWD_POS_W'(fwd_col);
   assign fwd_jpos = FWD_COL_W'(key_lo - COL_FIRST);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);

   assign syl_we  = accept && (req_cmd == CMD_LOAD_SYLLABLE)
                    && (32'(req_entry_index) < SYLLABLE_ENTRIES);
   assign jamo_we = accept && (req_cmd == CMD_LOAD_JAMO)
                    && (32'(req_entry_index) < JAMO_ENTRIES);

   always_comb begin
      unique case (state_ff)
         ST_FWD:   syl_addr = SYL_AW'(fwd_pos);
         ST_PROBE: syl_addr = SYL_AW'(mid_calc);
         default:  syl_addr = SYL_AW'(req_entry_index);
      endcase
      unique case (state_ff)
         ST_FWD:   jamo_addr = JAMO_AW'(fwd_jpos);
         ST_JREAD: jamo_addr = JAMO_AW'(j_ff);
         default:  jamo_addr = JAMO_AW'(req_entry_index);
      endcase
   end

   always_ff @(posedge clock) begin
      if (syl_we) begin
         syl_mem_ff[syl_addr] <= req_code_in;
      end
      syl_rd_ff <= syl_mem_ff[syl_addr];
   end

   always_ff @(posedge clock) begin
      if (jamo_we) begin
         jamo_mem_ff[jamo_addr] <= req_code_in;
      end
      jamo_rd_ff <= jamo_mem_ff[jamo_addr];
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      sel_jamo_in  = sel_jamo_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rem_in       = rem_ff;
      row_in       = row_ff;
      j_in         = j_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      code_out_in  = code_out_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in = req_code_in;
               lo_in  = '0;
               hi_in  = SYL_CW'(SYLLABLE_ENTRIES);
               unique case (req_cmd)
                  CMD_TO_JOHAB: begin
                     state_in = ST_FWD;
                  end
                  CMD_TO_WANSUNG: begin
                     if ((req_code_in & JOHAB_FLAG) == '0) begin
                        res_in   = req_code_in;
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_PROBE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FWD: begin
            priority if (key_hi == 8'h00) begin
               res_in   = {8'h00, key_lo};
               state_in = ST_FINISH;
            end else if (key_hi == JAMO_ROW) begin
               if ((key_lo >= COL_FIRST) && (key_lo <= JAMO_LAST)
                   && (32'(fwd_jpos) < JAMO_ENTRIES)) begin
                  sel_jamo_in = 1'b1;
                  state_in    = ST_FWD_WAIT;
               end else begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end
            end else if ((key_hi >= ROW_FIRST) && (key_hi <= ROW_LAST)
                         && (key_lo >= COL_FIRST) && (key_lo <= COL_LAST)
                         && (32'(fwd_pos) < SYLLABLE_ENTRIES)) begin
               sel_jamo_in = 1'b0;
               state_in    = ST_FWD_WAIT;
            end else begin
               res_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FWD_WAIT: begin
            res_in   = sel_jamo_ff ? jamo_rd_ff : syl_rd_ff;
            state_in = ST_FINISH;
         end
         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               state_in = ST_COMPARE;
            end else begin
               j_in     = '0;
               state_in = ST_JREAD;
            end
         end
         ST_COMPARE: begin
            priority if (syl_rd_ff == key_ff) begin
               rem_in   = mid_ff;
               row_in   = '0;
               state_in = ST_DIVIDE;
            end else if (key_ff < syl_rd_ff) begin
               hi_in    = mid_ff;
               state_in = ST_PROBE;
            end else begin
               lo_in    = mid_ff + SYL_CW'(1);
               state_in = ST_PROBE;
            end
         end
         ST_DIVIDE: begin
            if (rem_ff >= SYL_CW'(ROWS_COLS)) begin
               rem_in = rem_ff - SYL_CW'(ROWS_COLS);
               row_in = row_ff + ROW_W'(1);
            end else begin
               res_in   = 16'((16'(ROW_FIRST) + 16'(row_ff)) << 8)
                          + 16'(rem_ff) + 16'(COL_FIRST);
               state_in = ST_FINISH;
            end
         end
         ST_JREAD: begin
            if (32'(j_ff) < JAMO_ENTRIES) begin
               state_in = ST_JCOMPARE;
            end else begin
               res_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_JCOMPARE: begin
            if (jamo_rd_ff == key_ff) begin
               res_in   = JAMO_WANSUNG + 16'(j_ff);
               state_in = ST_FINISH;
            end else begin
               j_in     = j_ff + JAMO_CW'(1);
               state_in = ST_JREAD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               code_out_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      sel_jamo_ff <= sel_jamo_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      rem_ff      <= rem_in;
      row_ff      <= row_in;
      j_ff        <= j_in;
      res_ff      <= res_in;
      code_out_ff <= code_out_in;
   end

   // The search window never inverts and every probe lies inside it.
   a_window_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (lo_ff <= hi_ff) && (hi_ff <= SYL_CW'(SYLLABLE_ENTRIES)))
      else $error("binary search window inverted");

   a_probe_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE) |-> (mid_ff >= lo_ff) && (mid_ff < hi_ff))
      else $error("probe outside the search window");

   // A load item finishes in the cycle it is accepted.
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      accept && ((req_cmd == CMD_LOAD_SYLLABLE) || (req_cmd == CMD_LOAD_JAMO))
      |=> (state_ff == ST_IDLE))
      else $error("load item left the idle state");

   // A conversion item always occupies the sequencer.
   a_convert_busy: assert property (@(posedge clock) disable iff (reset)
      accept && ((req_cmd == CMD_TO_JOHAB) || (req_cmd == CMD_TO_WANSUNG))
      |=> !req_ready)
      else $error("conversion item did not start");

   // The jamo scan never runs past the end of the table.
   a_jamo_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_JCOMPARE) |-> (32'(j_ff) < JAMO_ENTRIES))
      else $error("jamo scan beyond table");

endmodule
